### sv/qu2x_pkg.sv
`timescale 1ns / 1ps

package qu2x_pkg;

  // item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_RL
  } state_t;

  // which of the four neighbors is fetched: a = base row/col, b = next row/col
  typedef enum logic [1:0] {
    F_AA,
    F_AB,
    F_BA,
    F_BB
  } fetch_t;

  // controller to datapath commands
  typedef struct packed {
    logic   load;  // latch the accepted word
    logic   wr;    // store the latched pixel
    logic   rd;    // issue a read of neighbor sel
    fetch_t sel;
    logic   fin;   // last read data is on the RAM output, form the result
  } cmd_t;

endpackage

### sv/qu2x_ram.sv
`timescale 1ns / 1ps

module qu2x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/qu2x_ctrl.sv
`timescale 1ns / 1ps

module qu2x_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             func,
  output logic             busy,
  output qu2x_pkg::cmd_t   cmd
);

  qu2x_pkg::state_t state;
  qu2x_pkg::state_t state_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qu2x_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    busy       = 1'b1;
    accept     = 1'b0;
    state_next = state;
    cmd        = '0;
    cmd.sel    = qu2x_pkg::F_AA;
    case (state)
      qu2x_pkg::ST_IDLE, qu2x_pkg::ST_RL: begin
        busy    = 1'b0;
        accept  = start;
        cmd.fin = (state == qu2x_pkg::ST_RL);
        if (start) begin
          state_next = (func == qu2x_pkg::FUNC_READ) ? qu2x_pkg::ST_R0 : qu2x_pkg::ST_WR;
        end else begin
          state_next = qu2x_pkg::ST_IDLE;
        end
      end
      qu2x_pkg::ST_WR: begin
        cmd.wr     = 1'b1;
        state_next = qu2x_pkg::ST_IDLE;
      end
      qu2x_pkg::ST_R0: begin
        cmd.rd     = 1'b1;
        cmd.sel    = qu2x_pkg::F_AA;
        state_next = qu2x_pkg::ST_R1;
      end
      qu2x_pkg::ST_R1: begin
        cmd.rd     = 1'b1;
        cmd.sel    = qu2x_pkg::F_AB;
        state_next = qu2x_pkg::ST_R2;
      end
      qu2x_pkg::ST_R2: begin
        cmd.rd     = 1'b1;
        cmd.sel    = qu2x_pkg::F_BA;
        state_next = qu2x_pkg::ST_R3;
      end
      qu2x_pkg::ST_R3: begin
        cmd.rd     = 1'b1;
        cmd.sel    = qu2x_pkg::F_BB;
        state_next = qu2x_pkg::ST_RL;
      end
      default: begin
        state_next = qu2x_pkg::ST_IDLE;
      end
    endcase
    cmd.load = accept;
  end

endmodule

### sv/qu2x_dp.sv
`timescale 1ns / 1ps

module qu2x_dp #(
  parameter int IMG_SIZE = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  qu2x_pkg::cmd_t cmd,
  input  logic           cfg_wr,
  input  logic [1:0]     quadrant,
  input  logic           func,
  input  logic [7:0]     row,
  input  logic [7:0]     col,
  input  logic [7:0]     pixel,
  output logic           done,
  output logic [7:0]     value
);

  localparam int HALF = IMG_SIZE / 2;
  localparam int HW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int AW   = $clog2(HALF * HALF);
  localparam int CW   = ($clog2(2 * HALF + 1) > 8) ? $clog2(2 * HALF + 1) : 9;

  logic [1:0]    quad_sel;
  logic [HW-1:0] a_r, b_r, a_c, b_c;
  logic          row_odd, col_odd, wr_ok;
  logic [7:0]    pix;
  logic [7:0]    p0, p1, p2;

  logic [CW-1:0] row_x, col_x, row_s, col_s, lim, r0, c0;
  logic [HW-1:0] sr, sc, sr1, sc1;
  logic          in_q;
  logic [HW-1:0] rr, cc;
  logic [AW-1:0] addr;
  logic          we;
  logic [7:0]    rdata;
  logic [8:0]    top9, bot9, v9;
  logic [7:0]    top, bot, v;

  // quadrant register
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_sel <= 2'd0;
    end else if (cfg_wr) begin
      quad_sel <= quadrant;
    end
  end

  // coordinate decode of the incoming word
  always_comb begin
    row_x = CW'(row);
    col_x = CW'(col);
    lim   = CW'(2 * HALF - 1);
    row_s = (row_x > lim) ? lim : row_x;
    col_s = (col_x > lim) ? lim : col_x;
    sr    = HW'(row_s >> 1);
    sc    = HW'(col_s >> 1);
    sr1   = (sr == HW'(HALF - 1)) ? sr : sr + HW'(1);
    sc1   = (sc == HW'(HALF - 1)) ? sc : sc + HW'(1);
    r0    = quad_sel[1] ? CW'(HALF) : '0;
    c0    = quad_sel[0] ? CW'(HALF) : '0;
    in_q  = (row_x >= r0) && (row_x < r0 + CW'(HALF)) &&
            (col_x >= c0) && (col_x < c0 + CW'(HALF));
  end

  // latch the accepted word; writes keep quadrant-relative position in a_r/a_c
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (func == qu2x_pkg::FUNC_WRITE) begin
        a_r   <= HW'(row_x - r0);
        a_c   <= HW'(col_x - c0);
        wr_ok <= in_q;
        pix   <= pixel;
      end else begin
        a_r     <= sr;
        b_r     <= sr1;
        a_c     <= sc;
        b_c     <= sc1;
        row_odd <= row_s[0];
        col_odd <= col_s[0];
      end
    end
  end

  // RAM address select
  always_comb begin
    case (cmd.sel)
      qu2x_pkg::F_AA: begin rr = a_r; cc = a_c; end
      qu2x_pkg::F_AB: begin rr = a_r; cc = b_c; end
      qu2x_pkg::F_BA: begin rr = b_r; cc = a_c; end
      default:        begin rr = b_r; cc = b_c; end
    endcase
    addr = AW'(AW'(rr) * AW'(HALF) + AW'(cc));
    we   = cmd.wr && wr_ok;
  end

  qu2x_ram #(
    .WIDTH (8),
    .DEPTH (HALF * HALF)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (pix),
    .rdata (rdata)
  );

  // capture each of the first three neighbors from the registered RAM output while the next address is issued
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      case (cmd.sel)
        qu2x_pkg::F_AB: p0 <= rdata;
        qu2x_pkg::F_BA: p1 <= rdata;
        qu2x_pkg::F_BB: p2 <= rdata;
        default: ;
      endcase
    end
  end

  // horizontal then vertical floor averages; fourth neighbor straight from RAM
  always_comb begin
    top9 = {1'b0, p0} + {1'b0, p1};
    bot9 = {1'b0, p2} + {1'b0, rdata};
    top  = col_odd ? top9[8:1] : p0;
    bot  = col_odd ? bot9[8:1] : p2;
    v9   = {1'b0, top} + {1'b0, bot};
    v    = row_odd ? v9[8:1] : top;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      value <= v;
    end
  end

endmodule

### sv/quadrant_upscale_2x.sv
`timescale 1ns / 1ps

// 2x enlargement of one quadrant of a grayscale image. A word is taken when
// start is high and busy is low. A write (func 0) stores pixel if row/col lie
// in the quadrant selected by the config register; it holds busy for one
// cycle. A read (func 1) returns one enlarged pixel: done pulses for exactly
// one cycle with value, both registered once the last neighbor is on the RAM
// output, and the receiver cannot stall it. A read occupies the block while
// it fetches its four neighbors in turn from the single-port pixel RAM, and
// the next word can be taken in the cycle after the last fetch, so no new
// word is taken while a read is still fetching. The config port is always
// ready; write it only while no read is outstanding. Reading a never-written
// pixel gives an undefined result.
module quadrant_upscale_2x #(
  parameter int IMG_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       func,
  input  logic [7:0] row,
  input  logic [7:0] col,
  input  logic [7:0] pixel,
  output logic       done,
  output logic [7:0] value,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] quadrant
);

  qu2x_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  qu2x_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .busy  (busy),
    .cmd   (cmd)
  );

  qu2x_dp #(
    .IMG_SIZE (IMG_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_wr   (cfg_valid && cfg_ready),
    .quadrant (quadrant),
    .func     (func),
    .row      (row),
    .col      (col),
    .pixel    (pixel),
    .done     (done),
    .value    (value)
  );

endmodule

### sv/qu2x_chk.sv
`timescale 1ns / 1ps

module qu2x_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic done
);

  // a result strobe is never held high back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted word always occupies the block next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // every accepted read is answered by a done strobe
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func) |-> ##6 done)
    else $error("read result missing");

  // a write produces no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !func) |-> ##6 !done)
    else $error("result after write");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done after reset");

endmodule

bind quadrant_upscale_2x qu2x_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);

### test/tb_quadrant_upscale_2x.sv
`timescale 1ns / 1ps

module tb_quadrant_upscale_2x;

  localparam int HALF = 128;
  // quadrant register values, one per random phase, lowest slot first
  localparam logic [9:0] QUAD_PLAN = {2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
  localparam int PHASES = 5;
  localparam int PHASE_WORDS = 340;

  typedef struct {
    logic [7:0] r;
    logic [7:0] c;
    logic [7:0] v;
  } want_t;

  // Tracks the stored quadrant and predicts each enlarged pixel
  class upscale_board;
    logic [7:0] src_pix [HALF*HALF];
    bit src_seen [HALF*HALF];
    logic [1:0] quad;
    want_t wants[$];
    int errors;
    int reads;
    int stores;
    int drops;

    function new();
      quad = 2'd0;
      errors = 0;
      reads = 0;
      stores = 0;
      drops = 0;
      foreach (src_pix[i]) begin
        src_pix[i] = 8'd0;
        src_seen[i] = 1'b0;
      end
    endfunction

    function void set_quadrant(logic [1:0] q);
      quad = q;
    endfunction

    // source position to store index, edge neighbors replicate
    function int slot(int r, int c);
      if (r >= HALF) r = HALF - 1;
      if (c >= HALF) c = HALF - 1;
      return r * HALF + c;
    endfunction

    // source row sr interpolated at output column oc
    function int row_mix(int sr, int oc);
      int sc;
      sc = oc >> 1;
      if (oc % 2 == 0) return int'(src_pix[slot(sr, sc)]);
      return (int'(src_pix[slot(sr, sc)]) + int'(src_pix[slot(sr, sc + 1)])) >> 1;
    endfunction

    function logic [7:0] enlarged_at(int r, int c);
      int sr;
      int v;
      sr = r >> 1;
      if (r % 2 == 0) v = row_mix(sr, c);
      else v = (row_mix(sr, c) + row_mix(sr + 1, c)) >> 1;
      return v[7:0];
    endfunction

    // true when every source entry a read at (r, c) touches has been written
    function bit covered(int r, int c);
      for (int dr = 0; dr <= r % 2; dr++)
        for (int dc = 0; dc <= c % 2; dc++)
          if (!src_seen[slot((r >> 1) + dr, (c >> 1) + dc)]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_word(logic f, logic [7:0] r, logic [7:0] c, logic [7:0] p);
      int r0;
      int c0;
      int idx;
      want_t w;
      r0 = quad[1] ? HALF : 0;
      c0 = quad[0] ? HALF : 0;
      if (f == qu2x_pkg::FUNC_WRITE) begin
        if (int'(r) >= r0 && int'(r) < r0 + HALF && int'(c) >= c0 && int'(c) < c0 + HALF) begin
          idx = slot(int'(r) - r0, int'(c) - c0);
          src_pix[idx] = p;
          src_seen[idx] = 1'b1;
          stores++;
        end else begin
          drops++;
        end
      end else begin
        w.r = r;
        w.c = c;
        w.v = enlarged_at(int'(r), int'(c));
        wants.push_back(w);
        reads++;
      end
    endfunction

    function void check_value(logic [7:0] v);
      want_t w;
      if (wants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: value %0d", v);
        return;
      end
      w = wants.pop_front();
      if (v !== w.v) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at row %0d col %0d: expected %0d, got %0d", w.r, w.c, w.v, v);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic func;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel;
  logic done;
  logic [7:0] value;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_quadrant;

  upscale_board board;
  int patch_bases[$];
  bit no_idle;

  quadrant_upscale_2x dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .row(row),
    .col(col),
    .pixel(pixel),
    .done(done),
    .value(value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .quadrant(cfg_quadrant)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("tb_quadrant_upscale_2x failed");
    $finish;
  end

  // result words cannot be held off, check every strobe
  always @(posedge clk) begin
    if (!rst && done) board.check_value(value);
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_pixel();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return 8'd0;
    if (k < 4) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_src();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 0;
    if (k == 1) return HALF - 1;
    return $urandom_range(0, HALF - 1);
  endfunction

  task automatic send_word(logic f, logic [7:0] r, logic [7:0] c, logic [7:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    row <= r;
    col <= c;
    pixel <= p;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_word(f, r, c, p);
  endtask

  task automatic write_cfg(logic [1:0] q);
    cfg_valid <= 1'b1;
    cfg_quadrant <= q;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    board.set_quadrant(q);
  endtask

  // drain outstanding reads, then let a trailing write finish
  task automatic settle();
    start <= 1'b0;
    while (board.wants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write a 2x2 source neighborhood, then read enlarged pixels over it
  task automatic run_patch();
    int sr;
    int sc;
    int r0;
    int c0;
    int rr;
    int cc;
    sr = pick_src();
    sc = pick_src();
    r0 = board.quad[1] ? HALF : 0;
    c0 = board.quad[0] ? HALF : 0;
    for (int dr = 0; dr < 2; dr++)
      for (int dc = 0; dc < 2; dc++)
        // now and then a word of the patch is left out
        if ($urandom_range(0, 9) != 0)
          send_word(qu2x_pkg::FUNC_WRITE, 8'(r0 + ((sr + dr > HALF - 1) ? HALF - 1 : sr + dr)),
                    8'(c0 + ((sc + dc > HALF - 1) ? HALF - 1 : sc + dc)), pick_pixel());
    patch_bases.push_back(sr * HALF + sc);
    repeat ($urandom_range(1, 4)) begin
      rr = 2 * sr + $urandom_range(0, 1);
      cc = 2 * sc + $urandom_range(0, 1);
      if (board.covered(rr, cc))
        send_word(qu2x_pkg::FUNC_READ, 8'(rr), 8'(cc), 8'($urandom_range(0, 255)));
    end
  endtask

  // read anywhere already filled, falling back to an earlier patch
  task automatic run_read();
    int rr;
    int cc;
    int b;
    rr = $urandom_range(0, 255);
    cc = $urandom_range(0, 255);
    if (!board.covered(rr, cc)) begin
      if (patch_bases.size() == 0) return;
      b = patch_bases[$urandom_range(0, patch_bases.size() - 1)];
      rr = 2 * (b / HALF) + $urandom_range(0, 1);
      cc = 2 * (b % HALF) + $urandom_range(0, 1);
      if (!board.covered(rr, cc)) return;
    end
    send_word(qu2x_pkg::FUNC_READ, 8'(rr), 8'(cc), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int base;
    int spin;
    int k;
    board = new();
    rst = 1'b1;
    start = 1'b0;
    func = qu2x_pkg::FUNC_WRITE;
    row = 8'd0;
    col = 8'd0;
    pixel = 8'd0;
    cfg_valid = 1'b0;
    cfg_quadrant = 2'd0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // top-left corner, odd sums for the floor average
    send_word(qu2x_pkg::FUNC_WRITE, 8'd0, 8'd0, 8'd0);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd0, 8'd1, 8'd255);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd1, 8'd0, 8'd255);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd1, 8'd1, 8'd254);
    send_word(qu2x_pkg::FUNC_READ, 8'd0, 8'd0, 8'd0);
    send_word(qu2x_pkg::FUNC_READ, 8'd0, 8'd1, 8'd255);
    send_word(qu2x_pkg::FUNC_READ, 8'd1, 8'd0, 8'd0);
    send_word(qu2x_pkg::FUNC_READ, 8'd1, 8'd1, 8'd255);
    // bottom-right corner, edge replication
    send_word(qu2x_pkg::FUNC_WRITE, 8'd127, 8'd127, 8'd255);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd127, 8'd126, 8'd1);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd126, 8'd127, 8'd128);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd126, 8'd126, 8'd3);
    send_word(qu2x_pkg::FUNC_READ, 8'd255, 8'd255, 8'd0);
    send_word(qu2x_pkg::FUNC_READ, 8'd254, 8'd255, 8'd0);
    send_word(qu2x_pkg::FUNC_READ, 8'd255, 8'd254, 8'd0);
    send_word(qu2x_pkg::FUNC_READ, 8'd253, 8'd253, 8'd0);
    send_word(qu2x_pkg::FUNC_READ, 8'd252, 8'd252, 8'd0);
    // fill the entries a wrapped stray write would land on
    send_word(qu2x_pkg::FUNC_WRITE, 8'd72, 8'd5, 8'd10);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd72, 8'd6, 8'd21);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd73, 8'd5, 8'd30);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd73, 8'd6, 8'd43);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd5, 8'd72, 8'd50);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd5, 8'd73, 8'd61);
    // writes outside the quadrant are dropped
    send_word(qu2x_pkg::FUNC_WRITE, 8'd200, 8'd5, 8'd77);
    send_word(qu2x_pkg::FUNC_WRITE, 8'd5, 8'd200, 8'd88);
    send_word(qu2x_pkg::FUNC_READ, 8'd145, 8'd11, 8'd0);
    send_word(qu2x_pkg::FUNC_READ, 8'd10, 8'd145, 8'd0);

    // random phases, one quadrant setting each
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      write_cfg(QUAD_PLAN[2*phase +: 2]);
      no_idle = (phase == 2);
      base = board.reads + board.stores;
      while (board.reads + board.stores < base + PHASE_WORDS) begin
        if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
        k = $urandom_range(0, 9);
        if (k < 6) run_patch();
        else if (k < 8) run_read();
        else send_word(qu2x_pkg::FUNC_WRITE, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end

    // drain
    start <= 1'b0;
    spin = 0;
    while (board.wants.size() != 0 && spin < 1000) begin
      @(posedge clk);
      spin++;
    end
    repeat (10) @(posedge clk);

    $display("%0d enlarged reads checked, %0d source pixels stored, %0d stray writes dropped",
             board.reads, board.stores, board.drops);
    $display("%0d quadrant settings, corners and edges included, random idling on the input",
             PHASES);
    if (board.wants.size() != 0)
      $display("%0d expected values never arrived", board.wants.size());
    if (board.errors == 0 && board.wants.size() == 0) begin
      $display("tb_quadrant_upscale_2x passed");
    end else begin
      $display("tb_quadrant_upscale_2x failed");
    end
    $finish;
  end

endmodule

### quadrant_upscale_2x.f
sv/qu2x_pkg.sv
sv/qu2x_ram.sv
sv/qu2x_ctrl.sv
sv/qu2x_dp.sv
sv/quadrant_upscale_2x.sv
sv/qu2x_chk.sv
test/tb_quadrant_upscale_2x.sv
